/* rtl/rkxcrc_pkg.sv */
// Shared types and constants for the repeating-key XOR decryptor with CRC-32.
`default_nettype none

package rkxcrc_pkg;

  localparam int unsigned MaxKeyBytes = 16;
  localparam int unsigned KeyPosW     = $clog2(MaxKeyBytes);
  localparam int unsigned KeyLenW     = 5;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKey1   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKey2   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKey3   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyLen = 3'd4;

  // Reset key "STarYZgr3DL11", byte 0 in the low bits of word 0
  localparam logic [31:0] KeyWord0Rst = 32'd1918981203;
  localparam logic [31:0] KeyWord1Rst = 32'd1919375961;
  localparam logic [31:0] KeyWord2Rst = 32'd827081779;
  localparam logic [31:0] KeyWord3Rst = 32'd49;
  localparam logic [KeyLenW-1:0] KeyLenRst = 5'd13;

  typedef logic [MaxKeyBytes-1:0][7:0] key_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       frame_end;
  } req_t;

  typedef struct packed {
    logic [7:0]  plain_byte;
    logic [31:0] checksum;
    logic        frame_done;
  } rsp_t;

  // Running frame state: key position and CRC accumulator
  typedef struct packed {
    logic [KeyPosW-1:0] key_pos;
    logic [31:0]        crc;
  } frame_state_t;

endpackage

`default_nettype wire

/* rtl/repeating_key_xor_crc32.sv */
// Top level: repeating-key XOR decryptor with CRC-32 over each frame's plaintext.
`default_nettype none

// Decrypts a byte stream with a repeating key of 1 to 16 bytes and returns one
// response per request: the plaintext byte, and on a frame's last byte the
// final (inverted) reflected CRC-32 of all plaintext bytes in that frame, with
// checksum reading zero on every other response. After the last byte the key
// position returns to 0 and the CRC to all ones. Throughput is one byte per
// clock unless the output stalls, the response registered for the next cycle;
// the critical path is the key byte mux followed by the eight-step CRC XOR
// network feeding the response register. A request is taken whenever the
// response register is empty or being drained in the same cycle, so a stalled
// consumer only holds the input once one response is already waiting. Key
// words and key length are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// (index 0..3 key words, byte 0 in bits 7:0; index 4 key length, zero acts as
// one and above 16 as 16; other indexes are ignored) and should be changed only
// while the block is idle. Reset loads the key "STarYZgr3DL11" with length 13.
module repeating_key_xor_crc32 (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  // request channel
  input  var logic                              in_valid_i,
  output logic                                  in_ready_o,
  input  var rkxcrc_pkg::req_t                  in_req_i,
  // response channel
  output logic                                  out_valid_o,
  input  var logic                              out_ready_i,
  output rkxcrc_pkg::rsp_t                      out_rsp_o,
  // configuration writes
  input  var logic                              cfg_we_i,
  input  var logic [rkxcrc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  var logic [rkxcrc_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  rkxcrc_pkg::key_t                  key_q;
  logic [rkxcrc_pkg::KeyLenW-1:0]    key_len_q;
  rkxcrc_pkg::frame_state_t          state_q, state_d;
  rkxcrc_pkg::rsp_t                  rsp_q, rsp_d;
  logic                              out_valid_q;
  logic                              in_fire;

  // Config registers: four 32-bit key words plus key length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[3:0]   <= rkxcrc_pkg::KeyWord0Rst;
      key_q[7:4]   <= rkxcrc_pkg::KeyWord1Rst;
      key_q[11:8]  <= rkxcrc_pkg::KeyWord2Rst;
      key_q[15:12] <= rkxcrc_pkg::KeyWord3Rst;
      key_len_q    <= rkxcrc_pkg::KeyLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rkxcrc_pkg::CfgKey0:   key_q[3:0]   <= cfg_wdata_i;
        rkxcrc_pkg::CfgKey1:   key_q[7:4]   <= cfg_wdata_i;
        rkxcrc_pkg::CfgKey2:   key_q[11:8]  <= cfg_wdata_i;
        rkxcrc_pkg::CfgKey3:   key_q[15:12] <= cfg_wdata_i;
        rkxcrc_pkg::CfgKeyLen: key_len_q    <= cfg_wdata_i[rkxcrc_pkg::KeyLenW-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // Response register is free when empty or drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  rkxcrc_step u_step (
    .key_i     (key_q),
    .key_len_i (key_len_q),
    .state_i   (state_q),
    .req_i     (in_req_i),
    .state_o   (state_d),
    .rsp_o     (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.key_pos <= '0;
      state_q.crc     <= rkxcrc_pkg::CrcInit;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // A frame's last byte re-arms the key position and CRC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req_i.frame_end |=>
      state_q.key_pos == '0 && state_q.crc == rkxcrc_pkg::CrcInit)
    else $error("frame state not re-armed after last byte");

  // Checksum is zero on every response that is not a frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.frame_done |-> out_rsp_o.checksum == '0)
    else $error("nonzero checksum outside frame end");

  // Every accepted request yields a pending response next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted request produced no response");

endmodule

`default_nettype wire

/* rtl/rkxcrc_step.sv */
// Per-byte datapath: key byte select, XOR, CRC-32 byte fold and state advance.
`default_nettype none

module rkxcrc_step (
  input  var rkxcrc_pkg::key_t                   key_i,
  input  var logic [rkxcrc_pkg::KeyLenW-1:0]     key_len_i,
  input  var rkxcrc_pkg::frame_state_t           state_i,
  input  var rkxcrc_pkg::req_t                   req_i,
  output rkxcrc_pkg::frame_state_t               state_o,
  output rkxcrc_pkg::rsp_t                       rsp_o
);

  localparam logic [rkxcrc_pkg::KeyLenW-1:0] MaxLen =
    rkxcrc_pkg::KeyLenW'(rkxcrc_pkg::MaxKeyBytes);

  // Reflected CRC-32, eight bit steps
  function automatic logic [31:0] crc_fold(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = (c >> 1) ^ (c[0] ? rkxcrc_pkg::CrcPoly : 32'd0);
    end
    return c;
  endfunction

  logic [rkxcrc_pkg::KeyLenW-1:0] eff_len;
  logic [rkxcrc_pkg::KeyLenW-1:0] pos_inc;
  logic [7:0]                     plain;
  logic [31:0]                    crc_new;

  always_comb begin
    // length zero acts as one, anything above the key size is clamped
    priority if (key_len_i == '0) begin
      eff_len = rkxcrc_pkg::KeyLenW'(1);
    end else if (key_len_i > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = key_len_i;
    end
  end

  assign pos_inc = {1'b0, state_i.key_pos} + rkxcrc_pkg::KeyLenW'(1);
  assign plain   = req_i.cipher_byte ^ key_i[state_i.key_pos];
  assign crc_new = crc_fold(state_i.crc, plain);

  always_comb begin
    rsp_o.plain_byte = plain;
    if (req_i.frame_end) begin
      rsp_o.checksum   = ~crc_new;
      rsp_o.frame_done = 1'b1;
      state_o.key_pos  = '0;
      state_o.crc      = rkxcrc_pkg::CrcInit;
    end else begin
      rsp_o.checksum   = '0;
      rsp_o.frame_done = 1'b0;
      state_o.key_pos  = (pos_inc >= eff_len) ? '0 : pos_inc[rkxcrc_pkg::KeyPosW-1:0];
      state_o.crc      = crc_new;
    end
  end

endmodule

`default_nettype wire

/* bench/tb_repeating_key_xor_crc32.sv */
// Self-checking bench for the repeating-key XOR decryptor with per-frame CRC-32.
module tb_repeating_key_xor_crc32;
  timeunit 1ns;
  timeprecision 1ps;

  import rkxcrc_pkg::*;

  // Bench knobs
  localparam int unsigned GapMax     = 18;      // longest idle draw, both sides
  localparam int unsigned HoldAtA    = 200;     // response counts that start a long stall
  localparam int unsigned HoldAtB    = 560;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned TailCycles = 8;       // settle time once all responses are in
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseBytes = 104;     // random bytes per key setting
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned ErrPrintMax = 30;

  // First register index past the documented list; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd5;

  typedef enum logic [1:0] {
    StepByte,   // one cipher byte request
    StepCfg,    // one register write, issued only when the block is idle
    StepDrain   // pause until every response is back
  } step_kind_e;

  typedef struct {
    step_kind_e           kind;
    req_t                 req;
    int unsigned          gap;    // idle cycles after this request is taken
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
  } plan_step_t;

  // DUT connections; every input starts at a known value
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  repeating_key_xor_crc32 u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the block: key registers, key position and running CRC
  // ---------------------------------------------------------------------------
  logic [31:0]         key_word [4] = '{KeyWord0Rst, KeyWord1Rst, KeyWord2Rst, KeyWord3Rst};
  logic [KeyLenW-1:0]  key_len  = KeyLenRst;
  logic [KeyPosW-1:0]  key_pos  = '0;
  logic [31:0]         crc_acc  = CrcInit;

  rsp_t       decrypted_q [$];   // predicted responses, oldest first
  plan_step_t plan_q [$];        // everything the request side still has to do

  int unsigned err_count   = 0;
  int unsigned req_count   = 0;
  int unsigned rsp_count   = 0;
  int unsigned frame_count = 0;
  int unsigned cfg_count   = 0;
  int unsigned hold_count  = 0;
  int          in_flight   = 0;  // requests taken minus responses taken, NBA-updated
  int unsigned cycle_count = 0;

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= ErrPrintMax) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_fold_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the shadow by one cipher byte and return the response it must cause
  function automatic rsp_t decrypt_step(req_t r);
    rsp_t        o;
    logic [7:0]  kb;
    int unsigned eff_len;
    int unsigned nxt;
    kb = key_word[key_pos[3:2]][8*key_pos[1:0] +: 8];
    o.plain_byte = r.cipher_byte ^ kb;
    crc_acc = crc32_fold_byte(crc_acc, o.plain_byte);
    // zero length acts as one, anything past the key store as the full store
    eff_len = (key_len == 0) ? 1 : ((key_len > MaxKeyBytes) ? MaxKeyBytes : key_len);
    // a position left past a shortened key is still used once, then wraps
    nxt = key_pos + 1;
    if (nxt >= eff_len) nxt = 0;
    key_pos = nxt[KeyPosW-1:0];
    o.checksum   = '0;
    o.frame_done = 1'b0;
    if (r.frame_end) begin
      o.checksum   = ~crc_acc;
      o.frame_done = 1'b1;
      crc_acc      = CrcInit;
      key_pos      = '0;
    end
    return o;
  endfunction

  function automatic void write_key_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgKey0:   key_word[0] = data;
      CfgKey1:   key_word[1] = data;
      CfgKey2:   key_word[2] = data;
      CfgKey3:   key_word[3] = data;
      CfgKeyLen: key_len     = data[KeyLenW-1:0];
      default: ;  // spare indexes change nothing
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Plan builders
  // ---------------------------------------------------------------------------
  task automatic add_byte(logic [7:0] cb, logic is_last, int unsigned gap);
    plan_step_t s;
    s = '{kind: StepByte, req: '{cipher_byte: cb, frame_end: is_last}, gap: gap,
          idx: '0, data: '0};
    plan_q.push_back(s);
  endtask

  task automatic add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_step_t s;
    s = '{kind: StepCfg, req: '0, gap: 0, idx: idx, data: data};
    plan_q.push_back(s);
  endtask

  task automatic add_drain();
    plan_step_t s;
    s = '{kind: StepDrain, req: '0, gap: 0, idx: '0, data: '0};
    plan_q.push_back(s);
  endtask

  // Full key setting; junk above the length field must be masked off
  task automatic load_key(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                          logic [31:0] w3, logic [KeyLenW-1:0] len);
    logic [CfgDataW-1:0] len_word;
    len_word = ($urandom() & ~32'h1F) | CfgDataW'(len);
    add_cfg(CfgKey0, w0);
    add_cfg(CfgKey1, w1);
    add_cfg(CfgKey2, w2);
    add_cfg(CfgKey3, w3);
    add_cfg(CfgKeyLen, len_word);
  endtask

  task automatic add_frame(int unsigned n, int unsigned gap_max, bit close);
    for (int unsigned i = 0; i < n; i++) begin
      add_byte(8'($urandom_range(0, 255)), close && (i == n - 1),
               $urandom_range(0, gap_max));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: walks plan_q; register writes and drains wait for idle
  // ---------------------------------------------------------------------------
  plan_step_t  drv_step;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
      gap_left   <= 0;
    end else if (in_valid_i && !in_ready_o) begin
      // request still pending: hold valid and payload
    end else if (gap_left != 0) begin
      gap_left   <= gap_left - 1;
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
    end else if (plan_q.size() == 0) begin
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
    end else if (plan_q[0].kind == StepByte) begin
      drv_step   = plan_q.pop_front();
      in_req_i   <= drv_step.req;
      in_valid_i <= 1'b1;
      cfg_we_i   <= 1'b0;
      gap_left   <= drv_step.gap;
    end else if (in_valid_i || in_flight != 0) begin
      // a request went in this edge or responses are still out: let it drain
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
    end else begin
      drv_step    = plan_q.pop_front();
      in_valid_i  <= 1'b0;
      cfg_we_i    <= (drv_step.kind == StepCfg);
      cfg_idx_i   <= drv_step.idx;
      cfg_wdata_i <= drv_step.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random per-response stalls, calm stretches, two long holds
  // ---------------------------------------------------------------------------
  int unsigned rx_wait   = 0;
  int unsigned hold_left = 0;
  int unsigned rx_taken  = 0;

  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int unsigned w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
      hold_left   <= 0;
      rx_taken    <= 0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      rx_taken <= rx_taken + 1;
      // every third stretch of 80 responses runs with ready held high
      w = (((rx_taken / 80) % 3) == 1) ? 0 : $urandom_range(0, GapMax);
      if (rx_taken + 1 == HoldAtA || rx_taken + 1 == HoldAtB) begin
        // long back-pressure so the request side fills the block and stalls
        hold_left   <= HoldCycles;
        out_ready_i <= 1'b0;
        hold_count++;
      end else if (w == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_wait     <= w - 1;
        out_ready_i <= 1'b0;
      end
    end else if (rx_wait != 0) begin
      rx_wait     <= rx_wait - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on taken requests, checks taken responses in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    rsp_t want;
    logic took_in;
    logic took_out;
    if (rst_ni) begin
      took_in  = in_valid_i && in_ready_o;
      took_out = out_valid_o && out_ready_i;
      // a response at this edge always belongs to an earlier request: pop first
      if (took_out) begin
        rsp_count++;
        if (out_rsp_o.frame_done === 1'b1) frame_count++;
        if (decrypted_q.size() == 0) begin
          flag_error($sformatf("response %0d with no request outstanding", rsp_count));
        end else begin
          want = decrypted_q.pop_front();
          if (out_rsp_o.plain_byte !== want.plain_byte)
            flag_error($sformatf("response %0d plain_byte %02h, predicted %02h",
                                 rsp_count, out_rsp_o.plain_byte, want.plain_byte));
          if (out_rsp_o.checksum !== want.checksum)
            flag_error($sformatf("response %0d checksum %08h, predicted %08h",
                                 rsp_count, out_rsp_o.checksum, want.checksum));
          if (out_rsp_o.frame_done !== want.frame_done)
            flag_error($sformatf("response %0d frame_done %b, predicted %b",
                                 rsp_count, out_rsp_o.frame_done, want.frame_done));
        end
      end
      if (took_in) begin
        req_count++;
        decrypted_q.push_back(decrypt_step(in_req_i));
      end
      if (cfg_we_i) begin
        cfg_count++;
        write_key_reg(cfg_idx_i, cfg_wdata_i);
      end
      in_flight <= in_flight + int'(took_in) - int'(took_out);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses still due",
               cycle_count, decrypted_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset, end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       n;
    int unsigned       done_bytes;
    int unsigned       gmax;
    logic [KeyLenW-1:0] len;
    logic [31:0]       fill;

    // Reset key: run past the 13-byte wrap, with the byte extremes up front
    add_byte(8'h00, 1'b0, 0);
    add_byte(8'hFF, 1'b0, 0);
    add_byte(8'hAA, 1'b0, 1);
    add_byte(8'h55, 1'b0, 0);
    for (int i = 4; i < 13; i++) add_byte(8'($urandom_range(0, 255)), 1'b0, 0);
    add_byte(8'h80, 1'b1, 2);
    // single-byte frame
    add_byte(8'hFF, 1'b1, 3);
    // zero key length acts as one
    load_key($urandom(), $urandom(), $urandom(), $urandom(), 5'd0);
    add_byte(8'($urandom_range(0, 255)), 1'b0, 1);
    add_byte(8'($urandom_range(0, 255)), 1'b1, 0);
    // length past the key store acts as 16; then shorten it below the open
    // frame's position: that byte is still used before the wrap
    load_key($urandom(), $urandom(), $urandom(), $urandom(), 5'd31);
    add_frame(5, 2, 1'b0);
    add_cfg(CfgKeyLen, 32'd3);
    add_byte(8'($urandom_range(0, 255)), 1'b0, 0);
    add_byte(8'($urandom_range(0, 255)), 1'b1, 0);
    // writes to spare indexes must leave the key alone
    for (int i = CfgIdxSpare; i < (1 << CfgIdxW); i++) add_cfg(CfgIdxW'(i), $urandom());
    add_byte(8'($urandom_range(0, 255)), 1'b1, 0);

    // Random part: one key setting per phase, frames of mixed length, an open
    // frame may carry across a key change
    for (int p = 0; p < NumPhases; p++) begin
      fill = $urandom();
      case (p)
        0:       begin len = 5'd1;                          fill = '1; end
        1:       begin len = KeyLenW'(MaxKeyBytes);         fill = '0; end
        2:       len = 5'd0;
        3:       len = KeyLenW'($urandom_range(MaxKeyBytes + 1, 31));
        default: len = KeyLenW'($urandom_range(1, MaxKeyBytes));
      endcase
      if (p < 2) load_key(fill, fill, fill, fill, len);
      else       load_key($urandom(), $urandom(), $urandom(), $urandom(), len);
      gmax = ((p % 3) == 2) ? 0 : GapMax;   // some phases stream back to back
      done_bytes = 0;
      while (done_bytes < PhaseBytes) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
        if (n > PhaseBytes - done_bytes) n = PhaseBytes - done_bytes;
        add_frame(n, gmax, (done_bytes + n < PhaseBytes) || $urandom_range(0, 1));
        done_bytes += n;
        if ($urandom_range(0, 5) == 0) add_drain();
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample on the falling edge so the driver's pops have settled
    do @(negedge clk_i);
    while (plan_q.size() != 0 || in_valid_i || cfg_we_i || in_flight != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (decrypted_q.size() != 0)
      flag_error($sformatf("%0d predicted responses never arrived", decrypted_q.size()));

    $display("summary: %0d bytes in, %0d bytes out, %0d frames closed, %0d register writes",
             req_count, rsp_count, frame_count, cfg_count);
    $display("summary: key lengths 0/1/16/over-range, %0d long output stalls, %0d errors",
             hold_count, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
